// ===== src/sha1md_pkg.sv =====
// SHA-1 digest block: shared types, constants and round functions.
// No dependencies; used by the interfaces, controller, datapath and top level.
`timescale 1ns / 1ps

package sha1md_pkg;

  typedef logic [31:0] word_t;

  // Digest geometry
  localparam int NUM_WORDS  = 5;
  localparam int ROUNDS     = 80;
  localparam int LEN_BYTES  = 8;
  localparam int WIDX_W     = 3;
  localparam int RND_W      = 7;
  localparam int FILL_W     = 6;
  localparam int CNT_W      = 61;

  localparam logic [FILL_W-1:0] FILL_LAST    = 6'd63;  // next byte completes a block
  localparam logic [FILL_W-1:0] FILL_LEN_POS = 6'd56;  // first byte of the length field
  localparam logic [WIDX_W-1:0] LAST_WORD_IDX = 3'd4;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  // Chaining initial values
  localparam word_t IV [NUM_WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  // Byte insert source codes
  localparam logic [1:0] INS_DATA = 2'd0;
  localparam logic [1:0] INS_PAD  = 2'd1;
  localparam logic [1:0] INS_ZERO = 2'd2;
  localparam logic [1:0] INS_LEN  = 2'd3;

  // Round group codes
  localparam logic [1:0] PH_CH   = 2'd0;
  localparam logic [1:0] PH_PAR1 = 2'd1;
  localparam logic [1:0] PH_MAJ  = 2'd2;
  localparam logic [1:0] PH_PAR2 = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic              ins;
    logic [1:0]        ins_sel;
    logic              count;
    logic              shift_len;
    logic              load_work;
    logic              round;
    logic [1:0]        phase;
    logic              add_chain;
    logic              init;
    logic [WIDX_W-1:0] out_sel;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic fill_last;
    logic fill_len_pos;
  } dp_sts_t;

  function automatic word_t sha1_f(input logic [1:0] ph, input word_t b,
                                   input word_t c, input word_t d);
    word_t r;
    case (ph)
      PH_CH:   r = (b & c) | (~b & d);
      PH_MAJ:  r = (b & c) | (b & d) | (c & d);
      default: r = b ^ c ^ d;
    endcase
    return r;
  endfunction

  function automatic word_t sha1_k(input logic [1:0] ph);
    word_t r;
    case (ph)
      PH_CH:   r = 32'h5A827999;
      PH_PAR1: r = 32'h6ED9EBA1;
      PH_MAJ:  r = 32'h8F1BBCDC;
      default: r = 32'hCA62C1D6;
    endcase
    return r;
  endfunction

endpackage

// ===== src/sha1md_if.sv =====
// Valid/ready channel interfaces for the message byte input and digest output.
// Depends on sha1md_pkg for the word type.
`timescale 1ns / 1ps

interface sha1md_in_if import sha1md_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       end_of_message;

  modport source (output valid, data_byte, byte_valid, end_of_message, input ready);
  modport sink   (input valid, data_byte, byte_valid, end_of_message, output ready);
endinterface

interface sha1md_out_if import sha1md_pkg::*; ();
  logic              valid;
  logic              ready;
  word_t             digest_word;
  logic [WIDX_W-1:0] word_number;
  logic              last_word;

  modport source (output valid, digest_word, word_number, last_word, input ready);
  modport sink   (input valid, digest_word, word_number, last_word, output ready);
endinterface

// ===== src/sha1_message_digest_top.sv =====
// SHA-1 message digest top level: controller and datapath on valid/ready channels.
// Depends on sha1md_pkg, sha1md_if, sha1md_ctrl and sha1md_dp.
//   Throughput: one byte per cycle in intake; every 64th byte starts a compression (80 rounds,
//   then an add) during which no bytes are taken. End of message: pad and length bytes, one or
//   two compressions, then five digest words, one per cycle while the sink is ready.
//   Reset (rst_n low, synchronous): chaining words to the initial values, counts cleared.
`timescale 1ns / 1ps

module sha1_message_digest_top import sha1md_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  sha1md_in_if.sink    in_ch,
  sha1md_out_if.source out_ch
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  sha1md_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_byte_valid (in_ch.byte_valid),
    .in_end        (in_ch.end_of_message),
    .in_ready      (in_ch.ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .sts           (sts),
    .cmd           (cmd)
  );

  sha1md_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .data_byte   (in_ch.data_byte),
    .cmd         (cmd),
    .sts         (sts),
    .digest_word (out_ch.digest_word),
    .word_number (out_ch.word_number),
    .last_word   (out_ch.last_word)
  );

endmodule

// ===== src/sha1md_dp.sv =====
// SHA-1 datapath: block shift buffer doubling as message schedule, working
// and chaining words, fill and length counters. Depends on sha1md_pkg.
`timescale 1ns / 1ps

module sha1md_dp import sha1md_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        data_byte,
  input  dp_cmd_t           cmd,
  output dp_sts_t           sts,
  output word_t             digest_word,
  output logic [WIDX_W-1:0] word_number,
  output logic              last_word
);

  logic [511:0]      blk_r;      // byte 0 of the block ends up in the top byte
  logic [FILL_W-1:0] fill_r;
  logic [CNT_W-1:0]  cnt_r;      // message length in bytes; shifted out as bit length
  word_t             work_r [NUM_WORDS];
  word_t             chain_r [NUM_WORDS];

  logic [7:0] ins_byte;
  word_t      w0, w2, w8, w13, sched_x, w_new;
  word_t      f_val, t_val;

  // Byte source select
  always_comb begin
    case (cmd.ins_sel)
      INS_DATA: ins_byte = data_byte;
      INS_PAD:  ins_byte = PAD_BYTE;
      INS_ZERO: ins_byte = 8'h00;
      default:  ins_byte = cnt_r[CNT_W-1 -: 8];
    endcase
  end

  // Schedule taps: the oldest word sits at the top of the buffer
  assign w0      = blk_r[511 -: 32];
  assign w2      = blk_r[511 - 2*32 -: 32];
  assign w8      = blk_r[511 - 8*32 -: 32];
  assign w13     = blk_r[511 - 13*32 -: 32];
  assign sched_x = w13 ^ w8 ^ w2 ^ w0;
  assign w_new   = {sched_x[30:0], sched_x[31]};

  // Round function
  assign f_val = sha1_f(cmd.phase, work_r[1], work_r[2], work_r[3]);
  assign t_val = {work_r[0][26:0], work_r[0][31:27]} + f_val + work_r[4]
               + sha1_k(cmd.phase) + w0;

  // Block buffer: bytes shift in, schedule words shift through during rounds
  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      blk_r <= {blk_r[503:0], ins_byte};
    end else if (cmd.round) begin
      blk_r <= {blk_r[479:0], w_new};
    end
  end

  // Fill and length counters
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.init) begin
      fill_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (cmd.ins) begin
        fill_r <= fill_r + 1'b1;
      end
      if (cmd.count) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (cmd.shift_len) begin
        cnt_r <= {cnt_r[CNT_W-9:0], 8'h00};
      end
    end
  end

  // Working words
  always_ff @(posedge clk) begin
    if (cmd.load_work) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        work_r[i] <= chain_r[i];
      end
    end else if (cmd.round) begin
      work_r[0] <= t_val;
      work_r[1] <= work_r[0];
      work_r[2] <= {work_r[1][1:0], work_r[1][31:2]};
      work_r[3] <= work_r[2];
      work_r[4] <= work_r[3];
    end
  end

  // Chaining words
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.init) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        chain_r[i] <= IV[i];
      end
    end else if (cmd.add_chain) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        chain_r[i] <= chain_r[i] + work_r[i];
      end
    end
  end

  assign sts.fill_last    = (fill_r == FILL_LAST);
  assign sts.fill_len_pos = (fill_r == FILL_LEN_POS);

  // Digest word out of the chaining registers
  assign digest_word = chain_r[cmd.out_sel];
  assign word_number = cmd.out_sel;
  assign last_word   = (cmd.out_sel == LAST_WORD_IDX);

endmodule

// ===== src/sha1md_ctrl.sv =====
// SHA-1 controller: byte intake, padding sequence, round sequencing and
// digest word output. Depends on sha1md_pkg; drives sha1md_dp by command.
`timescale 1ns / 1ps

module sha1md_ctrl import sha1md_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_byte_valid,
  input  logic    in_end,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD80 = 3'd1;
  localparam logic [2:0] S_PADZ  = 3'd2;
  localparam logic [2:0] S_PADL  = 3'd3;
  localparam logic [2:0] S_ROUND = 3'd4;
  localparam logic [2:0] S_ADD   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  localparam logic [RND_W-1:0] RND_LAST = RND_W'(ROUNDS - 1);
  localparam logic [2:0]       LEN_LAST = 3'(LEN_BYTES - 1);

  logic [2:0]        state_r, state_nxt;
  logic [2:0]        ret_r, ret_nxt;     // where to go after a compression
  logic [RND_W-1:0]  rnd_r, rnd_nxt;
  logic [2:0]        lcnt_r, lcnt_nxt;
  logic [WIDX_W-1:0] widx_r, widx_nxt;
  logic [1:0]        phase;

  // Round group from round number
  always_comb begin
    if (rnd_r < RND_W'(20)) begin
      phase = PH_CH;
    end else if (rnd_r < RND_W'(40)) begin
      phase = PH_PAR1;
    end else if (rnd_r < RND_W'(60)) begin
      phase = PH_MAJ;
    end else begin
      phase = PH_PAR2;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    ret_nxt     = ret_r;
    rnd_nxt     = rnd_r;
    lcnt_nxt    = lcnt_r;
    widx_nxt    = widx_r;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd         = '0;
    cmd.phase   = phase;
    cmd.out_sel = widx_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_byte_valid) begin
            cmd.ins     = 1'b1;
            cmd.ins_sel = INS_DATA;
            cmd.count   = 1'b1;
          end
          if (in_byte_valid && sts.fill_last) begin
            cmd.load_work = 1'b1;
            rnd_nxt       = '0;
            state_nxt     = S_ROUND;
            ret_nxt       = in_end ? S_PAD80 : S_IDLE;
          end else if (in_end) begin
            state_nxt = S_PAD80;
          end
        end
      end
      S_PAD80: begin
        cmd.ins     = 1'b1;
        cmd.ins_sel = INS_PAD;
        if (sts.fill_last) begin
          cmd.load_work = 1'b1;
          rnd_nxt       = '0;
          state_nxt     = S_ROUND;
          ret_nxt       = S_PADZ;
        end else begin
          state_nxt = S_PADZ;
        end
      end
      S_PADZ: begin
        if (sts.fill_len_pos) begin
          lcnt_nxt  = '0;
          state_nxt = S_PADL;
        end else begin
          cmd.ins     = 1'b1;
          cmd.ins_sel = INS_ZERO;
          if (sts.fill_last) begin
            cmd.load_work = 1'b1;
            rnd_nxt       = '0;
            state_nxt     = S_ROUND;
            ret_nxt       = S_PADZ;
          end
        end
      end
      S_PADL: begin
        cmd.ins       = 1'b1;
        cmd.ins_sel   = INS_LEN;
        cmd.shift_len = 1'b1;
        lcnt_nxt      = lcnt_r + 1'b1;
        if (lcnt_r == LEN_LAST) begin
          cmd.load_work = 1'b1;
          rnd_nxt       = '0;
          widx_nxt      = '0;
          state_nxt     = S_ROUND;
          ret_nxt       = S_OUT;
        end
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        rnd_nxt   = rnd_r + 1'b1;
        if (rnd_r == RND_LAST) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        cmd.add_chain = 1'b1;
        state_nxt     = ret_r;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (widx_r == LAST_WORD_IDX) begin
            cmd.init  = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            widx_nxt = widx_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
      rnd_r   <= '0;
      lcnt_r  <= '0;
      widx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      rnd_r   <= rnd_nxt;
      lcnt_r  <= lcnt_nxt;
      widx_r  <= widx_nxt;
    end
  end

`ifndef SYNTHESIS
  // Intake and digest output never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while digest word pending");

  // Round counter stays inside the 80 rounds
  a_rnd_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND) |-> (rnd_r <= RND_LAST))
    else $error("round counter out of range");

  // Last length byte must complete a block in the datapath
  a_len_align: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PADL && lcnt_r == LEN_LAST) |-> sts.fill_last)
    else $error("length field not block aligned");

  // Taking the fifth word returns the block to intake
  a_out_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_ready && widx_r == LAST_WORD_IDX) |=> (state_r == S_IDLE))
    else $error("no return to intake after last digest word");
`endif

endmodule

// ===== test/sha1md_tb_pkg.sv =====
// Testbench package for the SHA-1 digest block: a predictor of the digest words
// and the queue of words still owed by the block. Depends on sha1md_pkg.
`timescale 1ns / 1ps

package sha1md_tb_pkg;
  import sha1md_pkg::*;

  typedef struct packed {
    word_t             digest_word;
    logic [WIDX_W-1:0] word_number;
    logic              last_word;
  } digest_beat_t;

  class sha1_digest_predictor;
    word_t        chain [NUM_WORDS];
    logic [511:0] block_buf;     // byte 0 of the block sits in bits 511:504
    int unsigned  fill;
    logic [60:0]  msg_len;
    digest_beat_t owed_words [$];
    int unsigned  errors;

    function new();
      block_buf = '0;
      errors    = 0;
      restart();
    endfunction

    function void restart();
      for (int i = 0; i < NUM_WORDS; i++) chain[i] = IV[i];
      fill    = 0;
      msg_len = '0;
    endfunction

    function word_t rol(word_t x, int unsigned r);
      return (x << r) | (x >> (32 - r));
    endfunction

    // 80-round compression of one 512-bit block into the chaining words
    function void compress(logic [511:0] blk);
      word_t w [80];
      word_t a, b, c, d, e, f, k, t;
      for (int i = 0; i < 16; i++) w[i] = blk[511 - 32 * i -: 32];
      for (int i = 16; i < 80; i++) w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
      for (int i = 0; i < 80; i++) begin
        if (i < 20) begin
          f = (b & c) | (~b & d);
          k = 32'h5A827999;
        end else if (i < 40) begin
          f = b ^ c ^ d;
          k = 32'h6ED9EBA1;
        end else if (i < 60) begin
          f = (b & c) | (b & d) | (c & d);
          k = 32'h8F1BBCDC;
        end else begin
          f = b ^ c ^ d;
          k = 32'hCA62C1D6;
        end
        t = rol(a, 5) + f + e + k + w[i];
        e = d;
        d = c;
        c = rol(b, 30);
        b = a;
        a = t;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
    endfunction

    // Pad byte, zeros and 64-bit bit length; may spill into a second block
    function void close_message();
      logic [511:0] blk;
      logic [63:0]  bit_len;
      int unsigned  pos;
      blk     = block_buf;
      bit_len = {msg_len, 3'b000};
      pos     = fill;
      blk[511 - 8 * pos -: 8] = PAD_BYTE;
      pos++;
      if (pos > 56) begin
        for (int i = pos; i < 64; i++) blk[511 - 8 * i -: 8] = 8'h00;
        compress(blk);
        pos = 0;
      end
      for (int i = pos; i < 56; i++) blk[511 - 8 * i -: 8] = 8'h00;
      blk[63:0] = bit_len;
      compress(blk);
    endfunction

    // Called for every accepted input word
    function void note_input(logic [7:0] data_byte, logic byte_valid, logic end_of_message);
      digest_beat_t beat;
      if (byte_valid) begin
        block_buf[511 - 8 * fill -: 8] = data_byte;
        fill++;
        msg_len++;
        if (fill == 64) begin
          compress(block_buf);
          fill = 0;
        end
      end
      if (end_of_message) begin
        close_message();
        for (int i = 0; i < NUM_WORDS; i++) begin
          beat.digest_word = chain[i];
          beat.word_number = i[WIDX_W-1:0];
          beat.last_word   = (i == NUM_WORDS - 1);
          owed_words.push_back(beat);
        end
        restart();
      end
    endfunction

    // Called for every accepted digest word
    function void check_result(word_t digest_word, logic [WIDX_W-1:0] word_number,
                               logic last_word);
      digest_beat_t want;
      if (owed_words.size() == 0) begin
        $error("unexpected digest word %h (word_number %0d)", digest_word, word_number);
        errors++;
        return;
      end
      want = owed_words.pop_front();
      if (digest_word !== want.digest_word) begin
        $error("digest_word: expected %h, actual %h", want.digest_word, digest_word);
        errors++;
      end
      if (word_number !== want.word_number) begin
        $error("word_number: expected %0d, actual %0d", want.word_number, word_number);
        errors++;
      end
      if (last_word !== want.last_word) begin
        $error("last_word: expected %0b, actual %0b", want.last_word, last_word);
        errors++;
      end
    endfunction
  endclass

endpackage

// ===== test/tb_sha1_message_digest_top.sv =====
// Testbench top for sha1_message_digest_top: directed and random byte messages,
// bursty sender, stalling receiver. Depends on sha1md_pkg, sha1md_if, sha1md_tb_pkg.
`timescale 1ns / 1ps

module tb_sha1_message_digest_top;
  import sha1md_pkg::*;
  import sha1md_tb_pkg::*;

  localparam int IDLE_LIMIT   = 4000;
  localparam int TAIL_CYCLES  = 300;
  localparam int TARGET_ITEMS = 120;
  localparam int MIN_MESSAGES = 3;

  logic clk;
  logic rst_n;

  sha1md_in_if  in_ch ();
  sha1md_out_if out_ch ();

  sha1_message_digest_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sha1_digest_predictor digest_model = new();

  int unsigned burst_left = 0;
  int unsigned item_count = 0;
  int unsigned msg_count  = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Byte source biased toward the extremes
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Send one word; bursts of random length with random gaps in between
  task automatic push_item(input logic [7:0] data_byte, input logic byte_valid,
                           input logic end_of_message);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_ch.valid          <= 1'b1;
    in_ch.data_byte      <= data_byte;
    in_ch.byte_valid     <= byte_valid;
    in_ch.end_of_message <= end_of_message;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
    if (byte_valid || end_of_message) item_count++;
    digest_model.note_input(data_byte, byte_valid, end_of_message);
  endtask

  // One message of len bytes, with stray no-op words and either form of ending
  task automatic send_message(input int unsigned len);
    logic end_alone;
    end_alone = (len == 0) || ($urandom_range(0, 3) == 0);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) push_item(pick_byte(), 1'b0, 1'b0);
      push_item(pick_byte(), 1'b1, (i == len - 1) && !end_alone);
    end
    if (end_alone) push_item(pick_byte(), 1'b0, 1'b1);
    msg_count++;
  endtask

  // Receiver: checks accepted digest words and stalls on its own pattern
  initial begin
    bit [31:0]   rx_cycle;
    int unsigned stall_left;
    rx_cycle     = '0;
    stall_left   = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        digest_model.check_result(out_ch.digest_word, out_ch.word_number, out_ch.last_word);
      rx_cycle++;
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (rx_cycle[9:8] != 2'b00 && $urandom_range(0, 5) == 0) begin
        // no new stalls start while rx_cycle[9:8] is zero
        out_ch.ready <= 1'b0;
        stall_left = $urandom_range(0, 11);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no word moving on either channel
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL sha1_message_digest_top");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    int unsigned len;
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.data_byte      <= 8'h00;
    in_ch.byte_valid     <= 1'b0;
    in_ch.end_of_message <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: no-op word, empty message, single extreme bytes, byte plus end,
    // end-only after bytes, ignored data on end-only words
    push_item(8'hA5, 1'b0, 1'b0);
    push_item(8'hFF, 1'b0, 1'b1);
    push_item(8'h00, 1'b1, 1'b1);
    push_item(8'hFF, 1'b1, 1'b1);
    push_item(8'h61, 1'b1, 1'b0);
    push_item(8'h62, 1'b1, 1'b0);
    push_item(8'h63, 1'b1, 1'b1);
    push_item(8'h61, 1'b1, 1'b0);
    push_item(8'h62, 1'b1, 1'b0);
    push_item(8'h00, 1'b0, 1'b0);
    push_item(8'h5A, 1'b0, 1'b1);
    push_item(8'h80, 1'b1, 1'b0);
    push_item(8'h7F, 1'b1, 1'b0);
    push_item(8'h00, 1'b0, 1'b1);
    push_item(8'hFF, 1'b0, 1'b0);
    push_item(8'h00, 1'b0, 1'b1);

    // Pad spilling into a second block, then a message that exactly fills a block
    send_message(56);
    send_message(64);
    // Random: short messages
    while (item_count < TARGET_ITEMS || msg_count < MIN_MESSAGES) begin
      case ($urandom_range(0, 9))
        9:       len = $urandom_range(0, 3);
        default: len = $urandom_range(0, 20);
      endcase
      send_message(len);
    end
    in_ch.valid <= 1'b0;

    // Drain: the watchdog covers a block that never delivers
    while (digest_model.owed_words.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (digest_model.errors == 0) begin
      $display("PASS sha1_message_digest_top");
    end else begin
      $display("FAIL sha1_message_digest_top");
    end
    $finish;
  end

endmodule
